// File: hw/rtl/mecanum_wheel_speed_mixer_defines.svh
// ----------------------------------------------------------------------------
// Mecanum wheel speed mixer assertion macros
// Concurrent property shorthands for the mixer's checker.
// ----------------------------------------------------------------------------
`ifndef MECANUM_WHEEL_SPEED_MIXER_DEFINES_SVH
`define MECANUM_WHEEL_SPEED_MIXER_DEFINES_SVH

// Same-cycle implication, disabled while reset is low
`define MWSM_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is low
`define MWSM_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hw/rtl/mwsm_pkg.sv
// ----------------------------------------------------------------------------
// Mecanum wheel speed mixer package
// Payload types, register indexes, widths and reset values.
// ----------------------------------------------------------------------------
package mwsm_pkg;

  localparam int unsigned SpeedW   = 16;
  localparam int unsigned WheelW   = 16;
  localparam int unsigned LimitW   = 13;
  localparam int unsigned RatioW   = 16;
  localparam int unsigned RpmW     = 24;
  localparam int unsigned MaxRpmW  = 15;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 24;

  typedef enum logic [CfgIdxW-1:0] {
    CfgVxLimit    = 3'd0,
    CfgVyLimit    = 3'd1,
    CfgVwLimit    = 3'd2,
    CfgBaseRatio  = 3'd3,
    CfgGimbalX    = 3'd4,
    CfgGimbalY    = 3'd5,
    CfgRpmRatio   = 3'd6,
    CfgMaxRpm     = 3'd7
  } cfg_reg_e;

  localparam logic [LimitW-1:0]  VxLimitRst   = 13'd3300;
  localparam logic [LimitW-1:0]  VyLimitRst   = 13'd3300;
  localparam logic [LimitW-1:0]  VwLimitRst   = 13'd300;
  localparam logic [RatioW-1:0]  BaseRatioRst = 16'd1920;
  localparam logic [RatioW-1:0]  GimbalXRst   = 16'd0;
  localparam logic [RatioW-1:0]  GimbalYRst   = 16'd0;
  localparam logic [RpmW-1:0]    RpmRatioRst  = 24'd110000;
  localparam logic [MaxRpmW-1:0] MaxRpmRst    = 15'd8500;

  localparam logic [WheelW-1:0] WheelMin = 16'h8000;
  localparam logic [WheelW-1:0] WheelMax = 16'h7FFF;

  typedef struct packed {
    logic signed [SpeedW-1:0] speed_x;
    logic signed [SpeedW-1:0] speed_y;
    logic signed [SpeedW-1:0] speed_w;
  } speed_cmd_t;

  typedef struct packed {
    logic signed [WheelW-1:0] wheel_fr;
    logic signed [WheelW-1:0] wheel_fl;
    logic signed [WheelW-1:0] wheel_bl;
    logic signed [WheelW-1:0] wheel_br;
    logic                     was_scaled;
  } wheel_out_t;

endpackage

// File: hw/rtl/mecanum_wheel_speed_mixer.sv
// ----------------------------------------------------------------------------
// Mecanum wheel speed mixer
// Throughput: one item per cycle while the output is not stalled; 22 stages:
// 5 arithmetic, max search, 15 divider steps and the output register.
// Every stage has its own valid bit; bubbles are filled while the output stalls.
// Reset clears all valid bits and loads the register defaults.
// ----------------------------------------------------------------------------
module mecanum_wheel_speed_mixer (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  mwsm_pkg::speed_cmd_t           in_data_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output mwsm_pkg::wheel_out_t           out_data_o,
  input  logic                           cfg_we_i,
  input  logic [mwsm_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [mwsm_pkg::CfgDataW-1:0]  cfg_wdata_i
);
  import mwsm_pkg::*;

  localparam int unsigned DivSteps  = MaxRpmW;
  localparam int unsigned StgClamp  = 0;
  localparam int unsigned StgMix    = 1;
  localparam int unsigned StgSum    = 2;
  localparam int unsigned StgProd   = 3;
  localparam int unsigned StgSat    = 4;
  localparam int unsigned StgDiv    = 5;
  localparam int unsigned StgOut    = StgDiv + DivSteps + 1;
  localparam int unsigned NumStg    = StgOut + 1;

  typedef struct packed {
    logic [13:0] vx;
    logic [13:0] vy;
    logic [13:0] vw;
  } clamp_t;

  typedef struct packed {
    logic [3:0][14:0] lin;
    logic [3:0][31:0] rot;
  } mix_t;

  typedef struct packed {
    logic [3:0][31:0] sum;
  } sum_t;

  typedef struct packed {
    logic [3:0][56:0] prod;
  } prod_t;

  typedef struct packed {
    logic [3:0][WheelW-1:0] wheel;
    logic [3:0][WheelW-1:0] mag;
    logic [3:0]             neg;
  } sat_t;

  typedef struct packed {
    logic [3:0][WheelW-1:0]  rem;
    logic [3:0][MaxRpmW-1:0] num;
    logic [3:0]              neg;
    logic [3:0][WheelW-1:0]  wheel;
    logic [WheelW-1:0]       max_mag;
    logic                    scale;
  } div_t;

  function automatic logic [13:0] clamp_mag(input logic signed [15:0] v,
                                            input logic [LimitW-1:0] lim);
    logic signed [15:0] hi;
    logic signed [15:0] lo;
    logic signed [15:0] r;
    hi = $signed({3'b000, lim});
    lo = -hi;
    priority if (v > hi) begin
      r = hi;
    end else if (v < lo) begin
      r = lo;
    end else begin
      r = v;
    end
    return r[13:0];
  endfunction

  function automatic div_t div_step(input div_t cur);
    div_t        nxt;
    logic [16:0] trial;
    logic [16:0] diff;
    logic        ge;
    nxt = cur;
    for (int k = 0; k < 4; k++) begin
      trial      = {cur.rem[k], cur.num[k][MaxRpmW-1]};
      diff       = trial - {1'b0, cur.max_mag};
      ge         = trial >= {1'b0, cur.max_mag};
      nxt.rem[k] = ge ? diff[WheelW-1:0] : trial[WheelW-1:0];
      nxt.num[k] = {cur.num[k][MaxRpmW-2:0], ge};
    end
    return nxt;
  endfunction

  logic [LimitW-1:0]  vx_limit_q, vy_limit_q, vw_limit_q;
  logic [RatioW-1:0]  base_ratio_q, gimbal_x_q, gimbal_y_q;
  logic [RpmW-1:0]    rpm_ratio_q;
  logic [MaxRpmW-1:0] max_rpm_q;

  logic [NumStg-1:0] vld_q, vld_d, adv;

  clamp_t     clamp_q, clamp_d;
  mix_t       mix_q, mix_d;
  sum_t       sum_q, sum_d;
  prod_t      prod_q, prod_d;
  sat_t       sat_q, sat_d;
  div_t       div_q [DivSteps+1];
  div_t       div_d [DivSteps+1];
  wheel_out_t out_q, out_d;

  logic signed [17:0] rat [4];
  logic signed [14:0] vx_ext, vy_ext;
  logic [56:0]        p_abs [4];
  logic [24:0]        p_mag [4];
  logic [WheelW-1:0]  max01, max23, max_all;
  logic [29:0]        num_full [4];
  logic [WheelW-1:0]  res [4];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vx_limit_q   <= VxLimitRst;
      vy_limit_q   <= VyLimitRst;
      vw_limit_q   <= VwLimitRst;
      base_ratio_q <= BaseRatioRst;
      gimbal_x_q   <= GimbalXRst;
      gimbal_y_q   <= GimbalYRst;
      rpm_ratio_q  <= RpmRatioRst;
      max_rpm_q    <= MaxRpmRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgVxLimit:   vx_limit_q   <= cfg_wdata_i[LimitW-1:0];
        CfgVyLimit:   vy_limit_q   <= cfg_wdata_i[LimitW-1:0];
        CfgVwLimit:   vw_limit_q   <= cfg_wdata_i[LimitW-1:0];
        CfgBaseRatio: base_ratio_q <= cfg_wdata_i[RatioW-1:0];
        CfgGimbalX:   gimbal_x_q   <= cfg_wdata_i[RatioW-1:0];
        CfgGimbalY:   gimbal_y_q   <= cfg_wdata_i[RatioW-1:0];
        CfgRpmRatio:  rpm_ratio_q  <= cfg_wdata_i[RpmW-1:0];
        CfgMaxRpm:    max_rpm_q    <= cfg_wdata_i[MaxRpmW-1:0];
      endcase
    end
  end

  // A stage advances when it is empty or everything downstream of it can move
  for (genvar g = 0; g < NumStg; g++) begin : g_adv
    assign adv[g] = ~(&vld_q[NumStg-1:g]) | ~out_stall_i;
  end

  assign vld_d      = {vld_q[NumStg-2:0], in_valid_i};
  assign in_stall_o = ~adv[StgClamp];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      for (int k = 0; k < NumStg; k++) begin
        if (adv[k]) begin
          vld_q[k] <= vld_d[k];
        end
      end
    end
  end

  always_comb begin
    clamp_d.vx = clamp_mag(in_data_i.speed_x, vx_limit_q);
    clamp_d.vy = clamp_mag(in_data_i.speed_y, vy_limit_q);
    clamp_d.vw = clamp_mag(in_data_i.speed_w, vw_limit_q);
  end

  always_comb begin
    rat[0] = $signed({2'b00, base_ratio_q}) - 18'($signed(gimbal_x_q))
           + 18'($signed(gimbal_y_q));
    rat[1] = $signed({2'b00, base_ratio_q}) - 18'($signed(gimbal_x_q))
           - 18'($signed(gimbal_y_q));
    rat[2] = $signed({2'b00, base_ratio_q}) + 18'($signed(gimbal_x_q))
           - 18'($signed(gimbal_y_q));
    rat[3] = $signed({2'b00, base_ratio_q}) + 18'($signed(gimbal_x_q))
           + 18'($signed(gimbal_y_q));
    vx_ext = 15'($signed(clamp_q.vx));
    vy_ext = 15'($signed(clamp_q.vy));
    mix_d.lin[0] = -vx_ext - vy_ext;
    mix_d.lin[1] =  vx_ext - vy_ext;
    mix_d.lin[2] =  vx_ext + vy_ext;
    mix_d.lin[3] = -vx_ext + vy_ext;
    for (int k = 0; k < 4; k++) begin
      mix_d.rot[k] = 32'($signed(clamp_q.vw)) * 32'(rat[k]);
    end
  end

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      sum_d.sum[k] = {{9{mix_q.lin[k][14]}}, mix_q.lin[k], 8'h00} + mix_q.rot[k];
    end
  end

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      prod_d.prod[k] = 57'($signed(sum_q.sum[k])) * 57'($signed({1'b0, rpm_ratio_q}));
    end
  end

  // Truncate toward zero, then saturate
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      sat_d.neg[k] = prod_q.prod[k][56];
      p_abs[k]     = sat_d.neg[k] ? (57'd0 - prod_q.prod[k]) : prod_q.prod[k];
      p_mag[k]     = p_abs[k][56:32];
      if (sat_d.neg[k]) begin
        sat_d.mag[k]   = (p_mag[k] > 25'(WheelMin)) ? WheelMin : p_mag[k][WheelW-1:0];
        sat_d.wheel[k] = 16'd0 - sat_d.mag[k];
      end else begin
        sat_d.mag[k]   = (p_mag[k] > 25'(WheelMax)) ? WheelMax : p_mag[k][WheelW-1:0];
        sat_d.wheel[k] = sat_d.mag[k];
      end
    end
  end

  always_comb begin
    max01   = (sat_q.mag[0] > sat_q.mag[1]) ? sat_q.mag[0] : sat_q.mag[1];
    max23   = (sat_q.mag[2] > sat_q.mag[3]) ? sat_q.mag[2] : sat_q.mag[3];
    max_all = (max01 > max23) ? max01 : max23;
    div_d[0].max_mag = max_all;
    div_d[0].scale   = max_all > {1'b0, max_rpm_q};
    div_d[0].neg     = sat_q.neg;
    div_d[0].wheel   = sat_q.wheel;
    for (int k = 0; k < 4; k++) begin
      num_full[k]     = 30'(sat_q.mag[k]) * 30'(max_rpm_q);
      div_d[0].rem[k] = {1'b0, num_full[k][29:MaxRpmW]};
      div_d[0].num[k] = num_full[k][MaxRpmW-1:0];
    end
    for (int j = 1; j <= DivSteps; j++) begin
      div_d[j] = div_step(div_q[j-1]);
    end
  end

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      if (div_q[DivSteps].scale) begin
        res[k] = div_q[DivSteps].neg[k] ? (16'd0 - {1'b0, div_q[DivSteps].num[k]})
                                         : {1'b0, div_q[DivSteps].num[k]};
      end else begin
        res[k] = div_q[DivSteps].wheel[k];
      end
    end
    out_d.wheel_fr   = res[0];
    out_d.wheel_fl   = res[1];
    out_d.wheel_bl   = res[2];
    out_d.wheel_br   = res[3];
    out_d.was_scaled = div_q[DivSteps].scale;
  end

  always_ff @(posedge clk_i) begin
    if (adv[StgClamp]) begin
      clamp_q <= clamp_d;
    end
    if (adv[StgMix]) begin
      mix_q <= mix_d;
    end
    if (adv[StgSum]) begin
      sum_q <= sum_d;
    end
    if (adv[StgProd]) begin
      prod_q <= prod_d;
    end
    if (adv[StgSat]) begin
      sat_q <= sat_d;
    end
    for (int j = 0; j <= DivSteps; j++) begin
      if (adv[StgDiv+j]) begin
        div_q[j] <= div_d[j];
      end
    end
    if (adv[StgOut]) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = vld_q[StgOut];
  assign out_data_o  = out_q;

endmodule

// File: hw/rtl/mwsm_checker.sv
// ----------------------------------------------------------------------------
// Mecanum wheel speed mixer checker
// Port-level properties of the mixer, bound to the mixer module.
// ----------------------------------------------------------------------------
`include "mecanum_wheel_speed_mixer_defines.svh"

module mwsm_checker (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 in_stall_o,
  input logic                 out_valid_o,
  input logic                 out_stall_i,
  input mwsm_pkg::wheel_out_t out_data_o
);
  import mwsm_pkg::*;

  `MWSM_ASSERT_NXT(a_out_valid_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o, "item dropped while stalled")
  `MWSM_ASSERT_NXT(a_out_data_hold, clk_i, rst_ni, out_valid_o && out_stall_i, $stable(out_data_o), "stalled item changed")
  `MWSM_ASSERT_IMP(a_in_stall_full, clk_i, rst_ni, in_stall_o, out_valid_o && out_stall_i, "input stalled with room in the pipeline")
  `MWSM_ASSERT_IMP(a_scaled_range, clk_i, rst_ni, out_valid_o && out_data_o.was_scaled, (out_data_o.wheel_fr != WheelMin) && (out_data_o.wheel_fl != WheelMin) && (out_data_o.wheel_bl != WheelMin) && (out_data_o.wheel_br != WheelMin), "scaled wheel out of range")

endmodule

bind mecanum_wheel_speed_mixer mwsm_checker u_checker (.*);

// File: tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// Mecanum wheel speed mixer testbench
// Sends chassis velocity commands under several register settings, input idle
// and output stall patterns. Each accepted command is mixed into four expected
// wheel speeds and a scaling flag by an independent integer model. Results are
// checked in order against those expectations.
// ----------------------------------------------------------------------------
module tb_top;
  import mwsm_pkg::*;

  typedef struct {
    logic        [LimitW-1:0]  vx_lim;
    logic        [LimitW-1:0]  vy_lim;
    logic        [LimitW-1:0]  vw_lim;
    logic        [RatioW-1:0]  base;
    logic signed [RatioW-1:0]  gx;
    logic signed [RatioW-1:0]  gy;
    logic        [RpmW-1:0]    rpm;
    logic        [MaxRpmW-1:0] max_rpm;
  } mix_cfg_t;

  class mix_board;
    mix_cfg_t    cfg;
    wheel_out_t  wheels_due[$];
    int unsigned mismatches;

    function longint clamp_mag(longint v, longint lim);
      if (v > lim) return lim;
      if (v < -lim) return -lim;
      return v;
    endfunction

    function longint wheel_speed(longint lin, longint vw, longint ratio);
      longint k;
      longint p;
      longint r;
      k = cfg.rpm;
      p = (lin * 256 + vw * ratio) * k;
      r = (p < 0) ? -((-p) >>> 32) : (p >>> 32);
      if (r > 32767) r = 32767;
      if (r < -32768) r = -32768;
      return r;
    endfunction

    function wheel_out_t mix_wheels(speed_cmd_t c);
      longint     vx, vy, vw, b, gx, gy, lim, top, mag;
      longint     w[4];
      wheel_out_t r;
      vx  = clamp_mag(c.speed_x, cfg.vx_lim);
      vy  = clamp_mag(c.speed_y, cfg.vy_lim);
      vw  = clamp_mag(c.speed_w, cfg.vw_lim);
      b   = cfg.base;
      gx  = cfg.gx;
      gy  = cfg.gy;
      lim = cfg.max_rpm;
      w[0] = wheel_speed(-vx - vy, vw, b - gx + gy);
      w[1] = wheel_speed( vx - vy, vw, b - gx - gy);
      w[2] = wheel_speed( vx + vy, vw, b + gx - gy);
      w[3] = wheel_speed(-vx + vy, vw, b + gx + gy);
      top = 0;
      foreach (w[i]) begin
        mag = (w[i] < 0) ? -w[i] : w[i];
        if (mag > top) top = mag;
      end
      r.was_scaled = top > lim;
      if (r.was_scaled) begin
        foreach (w[i]) begin
          mag = (w[i] < 0) ? -w[i] : w[i];
          mag = mag * lim / top;
          w[i] = (w[i] < 0) ? -mag : mag;
        end
      end
      r.wheel_fr = 16'(w[0]);
      r.wheel_fl = 16'(w[1]);
      r.wheel_bl = 16'(w[2]);
      r.wheel_br = 16'(w[3]);
      return r;
    endfunction

    function void note_command(speed_cmd_t c);
      wheels_due.push_back(mix_wheels(c));
    endfunction

    function void check_wheels(wheel_out_t got);
      wheel_out_t want;
      bit         bad;
      if (wheels_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected item: fr %0d fl %0d bl %0d br %0d scaled %0b",
                   got.wheel_fr, got.wheel_fl, got.wheel_bl, got.wheel_br,
                   got.was_scaled);
        return;
      end
      want = wheels_due.pop_front();
      bad = (got.wheel_fr !== want.wheel_fr) || (got.wheel_fl !== want.wheel_fl) ||
            (got.wheel_bl !== want.wheel_bl) || (got.wheel_br !== want.wheel_br) ||
            (got.was_scaled !== want.was_scaled);
      if (bad) begin
        mismatches++;
        if (mismatches <= 10)
          $display({"mismatch: want fr %0d fl %0d bl %0d br %0d scaled %0b,",
                    " got fr %0d fl %0d bl %0d br %0d scaled %0b"},
                   want.wheel_fr, want.wheel_fl, want.wheel_bl, want.wheel_br,
                   want.was_scaled, got.wheel_fr, got.wheel_fl, got.wheel_bl,
                   got.wheel_br, got.was_scaled);
      end
    endfunction
  endclass

  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                in_valid_i  = 1'b0;
  logic                in_stall_o;
  speed_cmd_t          in_data_i   = '0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  wheel_out_t          out_data_o;
  logic                cfg_we_i    = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i   = '0;
  logic [CfgDataW-1:0] cfg_wdata_i = '0;

  int       send_idle_pct = 0;
  int       stall_pct     = 0;
  mix_board board         = new();

  mecanum_wheel_speed_mixer dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      board.check_wheels(out_data_o);
    end
    out_stall_i <= ($urandom_range(99) < stall_pct);
  end

  initial begin
    #4000000;
    $display("tb_top NOT OK");
    $finish;
  end

  function automatic mix_cfg_t reset_settings();
    mix_cfg_t s;
    s.vx_lim  = VxLimitRst;
    s.vy_lim  = VyLimitRst;
    s.vw_lim  = VwLimitRst;
    s.base    = BaseRatioRst;
    s.gx      = GimbalXRst;
    s.gy      = GimbalYRst;
    s.rpm     = RpmRatioRst;
    s.max_rpm = MaxRpmRst;
    return s;
  endfunction

  function automatic logic [LimitW-1:0] pick_limit(logic [LimitW-1:0] rst);
    case ($urandom_range(5))
      0: return '0;
      1: return '1;
      2: return rst;
      default: return LimitW'($urandom);
    endcase
  endfunction

  function automatic logic signed [RatioW-1:0] pick_gimbal();
    case ($urandom_range(4))
      0: return '0;
      1: return 16'sh8000;
      2: return 16'sh7FFF;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic mix_cfg_t random_settings();
    mix_cfg_t s;
    s.vx_lim = pick_limit(VxLimitRst);
    s.vy_lim = pick_limit(VyLimitRst);
    s.vw_lim = pick_limit(VwLimitRst);
    case ($urandom_range(3))
      0: s.base = '0;
      1: s.base = '1;
      2: s.base = BaseRatioRst;
      default: s.base = 16'($urandom);
    endcase
    s.gx = pick_gimbal();
    s.gy = pick_gimbal();
    case ($urandom_range(4))
      0: s.rpm = RpmW'($urandom);
      1: s.rpm = '1;
      2: s.rpm = RpmRatioRst;
      default: s.rpm = RpmW'($urandom_range(400000, 1));
    endcase
    case ($urandom_range(4))
      0: s.max_rpm = '0;
      1: s.max_rpm = '1;
      2: s.max_rpm = MaxRpmRst;
      default: s.max_rpm = MaxRpmW'($urandom_range(600, 1));
    endcase
    return s;
  endfunction

  function automatic logic signed [SpeedW-1:0] pick_speed(logic [LimitW-1:0] lim);
    int l;
    l = lim;
    case ($urandom_range(5))
      0, 1: return 16'($urandom);
      2: return 16'($urandom_range(1) ? l : -l);
      3: return 16'($urandom_range(1) ? l + 1 : -l - 1);
      default: return 16'(int'($urandom_range(2 * l)) - l);
    endcase
  endfunction

  function automatic speed_cmd_t cmd(int x, int y, int w);
    speed_cmd_t c;
    c.speed_x = 16'(x);
    c.speed_y = 16'(y);
    c.speed_w = 16'(w);
    return c;
  endfunction

  function automatic logic [CfgDataW-1:0] reg_word(mix_cfg_t s, cfg_reg_e r);
    case (r)
      CfgVxLimit:   return CfgDataW'(s.vx_lim);
      CfgVyLimit:   return CfgDataW'(s.vy_lim);
      CfgVwLimit:   return CfgDataW'(s.vw_lim);
      CfgBaseRatio: return CfgDataW'(s.base);
      CfgGimbalX:   return CfgDataW'(s.gx);
      CfgGimbalY:   return CfgDataW'(s.gy);
      CfgRpmRatio:  return CfgDataW'(s.rpm);
      default:      return CfgDataW'(s.max_rpm);
    endcase
  endfunction

  task automatic apply_settings(input mix_cfg_t s);
    cfg_reg_e r;
    r = r.first();
    do begin
      cfg_we_i    <= 1'b1;
      cfg_idx_i   <= r;
      cfg_wdata_i <= reg_word(s, r);
      @(posedge clk_i);
      r = r.next();
    end while (r != r.first());
    cfg_we_i <= 1'b0;
    board.cfg = s;
  endtask

  task automatic send_cmd(input speed_cmd_t c);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= c;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    board.note_command(c);
  endtask

  // drop valid and wait for every outstanding item to drain
  task automatic settle(input int tail);
    in_valid_i <= 1'b0;
    while (board.wheels_due.size() != 0) @(posedge clk_i);
    repeat (tail) @(posedge clk_i);
  endtask

  initial begin
    mix_cfg_t   s;
    speed_cmd_t c;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    apply_settings(reset_settings());
    send_cmd(cmd(0, 0, 0));
    send_cmd(cmd(32767, 32767, 32767));
    send_cmd(cmd(-32768, -32768, -32768));
    send_cmd(cmd(3300, 0, 0));
    send_cmd(cmd(0, -3301, 0));
    send_cmd(cmd(0, 0, 301));
    send_cmd(cmd(0, 0, -300));
    send_cmd(cmd(1000, -2000, 150));
    send_cmd(cmd(1, -1, 1));
    settle(4);

    s = reset_settings();
    s.vx_lim = '0;
    s.vy_lim = '0;
    s.vw_lim = '0;
    apply_settings(s);
    send_cmd(cmd(32767, -32768, -32768));
    send_cmd(cmd(-5, 7, 9));
    settle(4);

    s.vx_lim  = '1;
    s.vy_lim  = '1;
    s.vw_lim  = '1;
    s.base    = '1;
    s.gx      = 16'sh8000;
    s.gy      = 16'sh7FFF;
    s.rpm     = '1;
    s.max_rpm = '1;
    apply_settings(s);
    send_cmd(cmd(32767, 32767, 32767));
    send_cmd(cmd(-32768, -32768, -32768));
    send_cmd(cmd(8191, -8191, 0));
    send_cmd(cmd(100, -3, -1));
    settle(4);

    s = reset_settings();
    s.max_rpm = '0;
    apply_settings(s);
    send_cmd(cmd(0, 0, 0));
    send_cmd(cmd(1000, 0, 0));
    send_cmd(cmd(-3300, 3300, -300));
    settle(4);

    s.max_rpm = 15'd20;
    apply_settings(s);
    send_cmd(cmd(3300, 1000, -200));
    settle(4);

    for (int p = 0; p < 8; p++) begin
      case (p % 4)
        0: begin
          send_idle_pct = 0;
          stall_pct     = 0;
        end
        1: begin
          send_idle_pct = 78;
          stall_pct     = 0;
        end
        2: begin
          send_idle_pct = 0;
          stall_pct     = 78;
        end
        default: begin
          send_idle_pct = 11;
          stall_pct     = 11;
        end
      endcase
      apply_settings((p == 0) ? reset_settings() : random_settings());
      repeat (85) begin
        c.speed_x = pick_speed(board.cfg.vx_lim);
        c.speed_y = pick_speed(board.cfg.vy_lim);
        c.speed_w = pick_speed(board.cfg.vw_lim);
        send_cmd(c);
      end
      settle((p == 7) ? 40 : 4);
    end

    if (board.mismatches == 0 && board.wheels_due.size() == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule
